// File: hw/rtl/matrix_multiply_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply core
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

// Same-cycle property
`define MMC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent now, consequent in the next cycle
`define MMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Field widths, operation codes and register indexes shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package mm_pkg;

	localparam int OP_W    = 2;
	localparam int ROW_W   = 3;
	localparam int VAL_W   = 16;
	localparam int PROD_W  = 32;
	localparam int SUM_W   = 35;
	localparam int CFG_W   = 4;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_START  = 2'd2
	} op_t;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_ROWS_A     = 2'd0;
	localparam reg_idx_t REG_INNER_SIZE = 2'd1;
	localparam reg_idx_t REG_COLS_B     = 2'd2;

	localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

endpackage

`default_nettype wire

// File: hw/rtl/mm_if.sv
// ----------------------------------------------------------------------------
// Matrix multiply stream interfaces
// Command beats (loads and start) and result beats, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm_cmd_if import mm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	op_t                     op;
	logic [ROW_W-1:0]        row;
	logic [ROW_W-1:0]        col;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output op, output row, output col, output value,
		input ready);
	modport sink (input valid, input op, input row, input col, input value,
		output ready);
endinterface

interface mm_res_if import mm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ROW_W-1:0]        out_row;
	logic [ROW_W-1:0]        out_col;
	logic signed [SUM_W-1:0] sum;
	logic                    last;

	modport source (output valid, output out_row, output out_col, output sum,
		output last, input ready);
	modport sink (input valid, input out_row, input out_col, input sum, input last,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/matrix_multiply_core.sv
// Load beats, like a start beat, are accepted only while idle.
// Each product element makes n operand reads through the single shared
// multiply-accumulate unit, then a three-stage drain (read, multiply, add).
// A start runs through all m * p elements; while a finished result waits on
// ready, the next element's first read is held back.
// Reset clears control state and sets all three size registers to 8; the
// operand stores are undefined until loaded.
// ----------------------------------------------------------------------------
// Matrix multiply core
// Loads A and B into local stores, then emits C = A x B element by element.
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_multiply_core_macros.svh"

module matrix_multiply_core import mm_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire  [PADDR_W-1:0]   paddr,
	input  wire  [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	mm_cmd_if.sink               cmd,
	mm_res_if.source             res
);

	localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ROW_W:0] GRID = (ROW_W + 1)'(MAX_DIM);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} state_t;

	// Clamp a size register and return the highest index it allows
	function automatic logic [DIM_W-1:0] size_last(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > CFG_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM - 1);
		end else begin
			r = DIM_W'(v - 1'b1);
		end
		return r;
	endfunction

	// Configuration registers
	logic [CFG_W-1:0] rows_a_q;
	logic [CFG_W-1:0] inner_size_q;
	logic [CFG_W-1:0] cols_b_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	// Sequencer
	state_t           state_q;
	logic [DIM_W-1:0] i_q, j_q, k_q;
	logic [DIM_W-1:0] m_last_q, n_last_q, p_last_q;
	logic             cmd_acc;
	logic             issue;
	logic             elem_last;

	// Operand stores
	logic signed [VAL_W-1:0] store_a [DEPTH];
	logic signed [VAL_W-1:0] store_b [DEPTH];
	logic                    in_grid;
	logic                    wr_a, wr_b;
	logic [AW-1:0]           wr_addr;
	logic [AW-1:0]           rd_addr_a, rd_addr_b;

	// Multiply-accumulate pipeline
	logic                     v_s1_q, v_s2_q;
	logic signed [VAL_W-1:0]  rd_a_s1, rd_b_s1;
	logic                     first_s1, lastk_s1, lastel_s1;
	logic [DIM_W-1:0]         i_s1, j_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     first_s2, lastk_s2, lastel_s2;
	logic [DIM_W-1:0]         i_s2, j_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  sum_next;
	logic                     res_load;

	// Result register
	logic                    out_valid_q;
	logic [ROW_W-1:0]        out_row_q, out_col_q;
	logic signed [SUM_W-1:0] out_sum_q;
	logic                    out_last_q;

	// Register write decode
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= SIZE_RESET;
			inner_size_q <= SIZE_RESET;
			cols_b_q     <= SIZE_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ROWS_A:     rows_a_q     <= pwdata[CFG_W-1:0];
				REG_INNER_SIZE: inner_size_q <= pwdata[CFG_W-1:0];
				REG_COLS_B:     cols_b_q     <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		case (cfg_idx)
			REG_ROWS_A:     prdata = PDATA_W'(rows_a_q);
			REG_INNER_SIZE: prdata = PDATA_W'(inner_size_q);
			REG_COLS_B:     prdata = PDATA_W'(cols_b_q);
			default:        prdata = '0;
		endcase
	end

	// Command handshake and store writes
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign in_grid   = ({1'b0, cmd.row} < GRID) && ({1'b0, cmd.col} < GRID);
	assign wr_a      = cmd_acc && (cmd.op == OP_LOAD_A) && in_grid;
	assign wr_b      = cmd_acc && (cmd.op == OP_LOAD_B) && in_grid;
	assign wr_addr   = AW'(AW'(cmd.row) * AW'(MAX_DIM)) + AW'(cmd.col);

	// Operand addresses: A[i][k] and B[k][j]
	assign rd_addr_a = AW'(AW'(i_q) * AW'(MAX_DIM)) + AW'(k_q);
	assign rd_addr_b = AW'(AW'(k_q) * AW'(MAX_DIM)) + AW'(j_q);

	// Hold the first read of an element until the result register is free
	assign issue     = (state_q == ST_MAC) &&
		!((k_q == '0) && out_valid_q && !res.ready);
	assign elem_last = (i_q == m_last_q) && (j_q == p_last_q);

	// Sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			m_last_q    <= '0;
			n_last_q    <= '0;
			p_last_q    <= '0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_sum_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc && (cmd.op == OP_START)) begin
						m_last_q <= size_last(rows_a_q);
						n_last_q <= size_last(inner_size_q);
						p_last_q <= size_last(cols_b_q);
						i_q      <= '0;
						j_q      <= '0;
						k_q      <= '0;
						state_q  <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (issue) begin
						if (k_q == n_last_q) begin
							k_q     <= '0;
							state_q <= ST_DRAIN;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					// Wait for the element to leave the pipeline, then advance
					if (!v_s1_q && !v_s2_q) begin
						if (elem_last) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_q == p_last_q) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							state_q <= ST_MAC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Load a finished element, else drop the result beat once taken
			if (res_load) begin
				out_valid_q <= 1'b1;
				out_row_q   <= ROW_W'(i_s2);
				out_col_q   <= ROW_W'(j_s2);
				out_sum_q   <= sum_next;
				out_last_q  <= lastel_s2;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (wr_a) begin
			store_a[wr_addr] <= cmd.value;
		end
		if (wr_b) begin
			store_b[wr_addr] <= cmd.value;
		end
		rd_a_s1 <= store_a[rd_addr_a];
		rd_b_s1 <= store_b[rd_addr_b];
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			v_s1_q <= issue;
			v_s2_q <= v_s1_q;
		end
	end

	// Carry element tags alongside the operands, multiply in stage two
	always_ff @(posedge clk) begin
		first_s1  <= (k_q == '0);
		lastk_s1  <= (k_q == n_last_q);
		lastel_s1 <= elem_last;
		i_s1      <= i_q;
		j_s1      <= j_q;
		prod_s2   <= rd_a_s1 * rd_b_s1;
		first_s2  <= first_s1;
		lastk_s2  <= lastk_s1;
		lastel_s2 <= lastel_s1;
		i_s2      <= i_s1;
		j_s2      <= j_s1;
	end

	// Accumulate, restarting on the first product of each element
	assign sum_next = (first_s2 ? SUM_W'(0) : acc_q) + SUM_W'(prod_s2);
	assign res_load = v_s2_q && lastk_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s2_q) begin
			acc_q <= sum_next;
		end
	end

	// Result port
	assign res.valid   = out_valid_q;
	assign res.out_row = out_row_q;
	assign res.out_col = out_col_q;
	assign res.sum     = out_sum_q;
	assign res.last    = out_last_q;

	// Checks
	`MMC_ASSERT(a_no_overwrite, !res_load || !out_valid_q || res.ready, "result beat overwritten")
	`MMC_ASSERT(a_idle_empty, (state_q != ST_IDLE) || (!v_s1_q && !v_s2_q), "pipeline busy while idle")
	`MMC_ASSERT(a_last_drained, !(res.valid && res.last) || (!v_s1_q && !v_s2_q), "work after last beat")
	`MMC_ASSERT_NEXT(a_last_to_idle, res_load && lastel_s2, (state_q == ST_DRAIN) && !v_s2_q, "last element not closing run")

endmodule

`default_nettype wire
